// File: hw/rtl/r2q_pkg.sv
package r2q_pkg;

	// Number format of matrix entries and quaternion components
	localparam int DATA_WIDTH    = 16;
	localparam int FRACTION_BITS = 14;
	localparam int ENTRIES       = 9;
	localparam int LANES         = 3;

	// Derived widths
	localparam int SUM_W   = DATA_WIDTH + 3;              // signed trace / root argument
	localparam int ARG_W   = SUM_W - 1;                   // clamped, non-negative argument
	localparam int RAD_W   = ARG_W + FRACTION_BITS;       // radicand before padding
	localparam int SQ_IN_W = RAD_W + (RAD_W % 2);         // radicand, even width
	localparam int ROOT_W  = SQ_IN_W / 2;                 // square root width
	localparam int DIFF_W  = DATA_WIDTH + 1;              // signed sum or difference of entries
	localparam int MAG_W   = DIFF_W;                      // magnitude of such a value
	localparam int NUM_W   = MAG_W + FRACTION_BITS + 1;   // dividend and quotient width
	localparam int DIV_W   = ROOT_W + 1;                  // divisor 2r

	// Path codes, also the row code of the largest diagonal entry
	localparam logic [1:0] PATH_TRACE = 2'd0;
	localparam logic [1:0] PATH_ROW0  = 2'd1;
	localparam logic [1:0] PATH_ROW1  = 2'd2;
	localparam logic [1:0] PATH_ROW2  = 2'd3;

	// Fixed-point one in the width of the trace sum
	localparam logic signed [SUM_W-1:0] ONE_SUM = SUM_W'(2 ** FRACTION_BITS);

	// Numerators as sign and magnitude, with the path they belong to
	typedef struct packed {
		logic [1:0]                  path;
		logic [LANES-1:0]            neg;
		logic [LANES-1:0][MAG_W-1:0] mag;
	} num_t;

	// What travels alongside the three dividers
	typedef struct packed {
		logic [1:0]        path;
		logic [LANES-1:0]  neg;
		logic [ROOT_W-1:0] root;
	} tag_t;

endpackage

// File: hw/rtl/rotation_matrix_to_quaternion_unit.sv
// Rotation matrix to quaternion, Shoemake's method, in signed Q2.14. One matrix
// is taken every cycle while the output is not stalled. The pipeline is trace
// and path choice, the sums, a bit-per-stage square root, dividend set-up,
// three bit-per-stage dividers and an output register. The whole pipeline
// holds while a result waits on m_tready; s_tready is low only then.
// Components are saturated, and a zero root gives zero for the three quotient
// components. m_tuser carries the path: trace positive, or the row of the
// largest diagonal entry.
module rotation_matrix_to_quaternion_unit (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                s_tvalid,
	output logic                                                s_tready,
	// m00, m01, m02, m10, m11, m12, m20, m21, m22, 16 bits each
	input  logic [r2q_pkg::ENTRIES*r2q_pkg::DATA_WIDTH-1:0]    s_tdata,
	output logic                                                m_tvalid,
	input  logic                                                m_tready,
	// quat_x, quat_y, quat_z, quat_w, 16 bits each
	output logic [4*r2q_pkg::DATA_WIDTH-1:0]                    m_tdata,
	// path_taken
	output logic [1:0]                                          m_tuser
);

	localparam int DW = r2q_pkg::DATA_WIDTH;
	localparam int NW = r2q_pkg::NUM_W;
	localparam logic [NW-1:0] POS_MAX = NW'(2 ** (DW - 1) - 1);
	localparam logic [NW-1:0] NEG_LIM = NW'(2 ** (DW - 1));

	logic                                            en;
	logic                                            fr_v;
	r2q_pkg::num_t                                   fr_nums;
	logic [r2q_pkg::ARG_W-1:0]                       fr_arg;
	logic                                            sq_v;
	logic [r2q_pkg::ROOT_W-1:0]                      sq_root;
	r2q_pkg::num_t                                   sq_nums;
	logic                                            dv_v;
	logic [r2q_pkg::LANES-1:0][NW-1:0]               dv_quo;
	r2q_pkg::tag_t                                   dv_tag;

	logic [r2q_pkg::LANES-1:0][DW-1:0]               lane_c;
	logic [r2q_pkg::ROOT_W:0]                        half_w;
	logic [DW-1:0]                                   half_c;
	logic [DW-1:0]                                   qx_c, qy_c, qz_c, qw_c;

	logic                                            out_v_q;
	logic [4*DW-1:0]                                 data_q;
	logic [1:0]                                      user_q;

	// Advance everything unless a result is held
	assign en       = !out_v_q || m_tready;
	assign s_tready = en;

	r2q_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.mat       (s_tdata),
		.out_valid (fr_v),
		.nums      (fr_nums),
		.arg       (fr_arg)
	);

	r2q_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_v),
		.arg       (fr_arg),
		.nums_in   (fr_nums),
		.out_valid (sq_v),
		.root      (sq_root),
		.nums_out  (sq_nums)
	);

	r2q_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_v),
		.root      (sq_root),
		.nums      (sq_nums),
		.out_valid (dv_v),
		.quo       (dv_quo),
		.tag       (dv_tag)
	);

	// Apply signs and saturate; zero root gives zero
	always_comb begin
		for (int l = 0; l < r2q_pkg::LANES; l++) begin
			if (dv_tag.root == '0) begin
				lane_c[l] = '0;
			end else if (dv_tag.neg[l]) begin
				lane_c[l] = (dv_quo[l] > NEG_LIM) ? NEG_LIM[DW-1:0]
					: DW'(-dv_quo[l]);
			end else begin
				lane_c[l] = (dv_quo[l] > POS_MAX) ? POS_MAX[DW-1:0]
					: dv_quo[l][DW-1:0];
			end
		end
		half_w = ((r2q_pkg::ROOT_W+1)'(dv_tag.root) + 1'b1) >> 1;
		half_c = ((NW)'(half_w) > POS_MAX) ? POS_MAX[DW-1:0] : DW'(half_w);
	end

	// Place the root component and the quotients by path
	always_comb begin
		case (dv_tag.path)
			r2q_pkg::PATH_ROW0: begin
				qx_c = half_c;    qw_c = lane_c[0];
				qy_c = lane_c[1]; qz_c = lane_c[2];
			end
			r2q_pkg::PATH_ROW1: begin
				qy_c = half_c;    qw_c = lane_c[0];
				qz_c = lane_c[1]; qx_c = lane_c[2];
			end
			r2q_pkg::PATH_ROW2: begin
				qz_c = half_c;    qw_c = lane_c[0];
				qx_c = lane_c[1]; qy_c = lane_c[2];
			end
			default: begin
				qw_c = half_c;    qx_c = lane_c[0];
				qy_c = lane_c[1]; qz_c = lane_c[2];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= dv_v;
		end
	end

	// Hold the result until its transfer
	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= {qw_c, qz_c, qy_c, qx_c};
			user_q <= dv_tag.path;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;

endmodule

// File: hw/rtl/r2q_front.sv
module r2q_front (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic                                                 en,
	input  logic                                                 in_valid,
	input  logic [r2q_pkg::ENTRIES*r2q_pkg::DATA_WIDTH-1:0]     mat,
	output logic                                                 out_valid,
	output r2q_pkg::num_t                                        nums,
	output logic [r2q_pkg::ARG_W-1:0]                            arg
);

	logic signed [r2q_pkg::DATA_WIDTH-1:0] m_in [r2q_pkg::ENTRIES];
	logic signed [r2q_pkg::SUM_W-1:0]      trace_c;
	logic [1:0]                            sel_c;

	logic signed [r2q_pkg::DATA_WIDTH-1:0] m_s1 [r2q_pkg::ENTRIES];
	logic signed [r2q_pkg::SUM_W-1:0]      trace_s1;
	logic [1:0]                            sel_s1;
	logic                                  v_s1;

	logic signed [r2q_pkg::SUM_W-1:0]      ex [r2q_pkg::ENTRIES];
	logic signed [r2q_pkg::DIFF_W-1:0]     dx [r2q_pkg::ENTRIES];
	logic signed [r2q_pkg::SUM_W-1:0]      arg_c;
	logic signed [r2q_pkg::DIFF_W-1:0]     n_c [r2q_pkg::LANES];
	logic [1:0]                            path_c;

	r2q_pkg::num_t                         nums_s2;
	logic [r2q_pkg::ARG_W-1:0]             arg_s2;
	logic                                  v_s2;

	// Unpack the entries, row by column
	for (genvar e = 0; e < r2q_pkg::ENTRIES; e++) begin : g_unpack
		assign m_in[e] = mat[e*r2q_pkg::DATA_WIDTH +: r2q_pkg::DATA_WIDTH];
	end

	// Trace and the largest diagonal entry; ties keep the lower row
	always_comb begin
		trace_c = r2q_pkg::SUM_W'(m_in[0]) + r2q_pkg::SUM_W'(m_in[4])
			+ r2q_pkg::SUM_W'(m_in[8]);
		if (m_in[4] > m_in[0]) begin
			sel_c = r2q_pkg::PATH_ROW1;
			if (m_in[8] > m_in[4]) begin
				sel_c = r2q_pkg::PATH_ROW2;
			end
		end else begin
			sel_c = r2q_pkg::PATH_ROW0;
			if (m_in[8] > m_in[0]) begin
				sel_c = r2q_pkg::PATH_ROW2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1     <= m_in;
			trace_s1 <= trace_c;
			sel_s1   <= sel_c;
		end
	end

	// Sign-extended copies for the sums below
	for (genvar e = 0; e < r2q_pkg::ENTRIES; e++) begin : g_ext
		assign ex[e] = r2q_pkg::SUM_W'(m_s1[e]);
		assign dx[e] = r2q_pkg::DIFF_W'(m_s1[e]);
	end

	// Root argument and the three numerators of the chosen path
	always_comb begin
		if (trace_s1 > 0) begin
			path_c = r2q_pkg::PATH_TRACE;
			arg_c  = trace_s1 + r2q_pkg::ONE_SUM;
			n_c[0] = dx[7] - dx[5];
			n_c[1] = dx[2] - dx[6];
			n_c[2] = dx[3] - dx[1];
		end else begin
			path_c = sel_s1;
			case (sel_s1)
				r2q_pkg::PATH_ROW1: begin
					arg_c  = ex[4] - ex[8] - ex[0] + r2q_pkg::ONE_SUM;
					n_c[0] = dx[2] - dx[6];
					n_c[1] = dx[7] + dx[5];
					n_c[2] = dx[1] + dx[3];
				end
				r2q_pkg::PATH_ROW2: begin
					arg_c  = ex[8] - ex[0] - ex[4] + r2q_pkg::ONE_SUM;
					n_c[0] = dx[3] - dx[1];
					n_c[1] = dx[2] + dx[6];
					n_c[2] = dx[5] + dx[7];
				end
				default: begin
					arg_c  = ex[0] - ex[4] - ex[8] + r2q_pkg::ONE_SUM;
					n_c[0] = dx[7] - dx[5];
					n_c[1] = dx[3] + dx[1];
					n_c[2] = dx[6] + dx[2];
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	// Clamp a negative argument to zero, split numerators into sign and magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			nums_s2.path <= path_c;
			arg_s2       <= (arg_c > 0) ? arg_c[r2q_pkg::ARG_W-1:0] : '0;
			for (int l = 0; l < r2q_pkg::LANES; l++) begin
				nums_s2.neg[l] <= n_c[l][r2q_pkg::DIFF_W-1];
				nums_s2.mag[l] <= n_c[l][r2q_pkg::DIFF_W-1]
					? r2q_pkg::MAG_W'(-n_c[l]) : r2q_pkg::MAG_W'(n_c[l]);
			end
		end
	end

	assign out_valid = v_s2;
	assign nums      = nums_s2;
	assign arg       = arg_s2;

endmodule

// File: hw/rtl/r2q_sqrt.sv
module r2q_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [r2q_pkg::ARG_W-1:0]    arg,
	input  r2q_pkg::num_t                nums_in,
	output logic                         out_valid,
	output logic [r2q_pkg::ROOT_W-1:0]   root,
	output r2q_pkg::num_t                nums_out
);

	localparam int N  = r2q_pkg::ROOT_W;
	localparam int RW = r2q_pkg::ROOT_W + 2;

	logic [r2q_pkg::SQ_IN_W-1:0] rad_s  [N+1];
	logic [RW-1:0]               rem_s  [N+1];
	logic [N-1:0]                root_s [N+1];
	r2q_pkg::num_t               tag_s  [N+1];
	logic                        v_s    [N+1];

	// Radicand is the argument scaled by one fraction unit
	assign rad_s[0]  = r2q_pkg::SQ_IN_W'({arg, {r2q_pkg::FRACTION_BITS{1'b0}}});
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign tag_s[0]  = nums_in;
	assign v_s[0]    = in_valid;

	// One root bit per stage: bring down two radicand bits, try 4r+1
	for (genvar g = 0; g < N; g++) begin : g_step
		logic [RW+1:0] cur;
		logic [RW+1:0] trial;
		logic          ge;

		always_comb begin
			cur   = {rem_s[g], rad_s[g][r2q_pkg::SQ_IN_W-1 -: 2]};
			trial = (RW+2)'({root_s[g], 2'b01});
			ge    = (cur >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1]  <= ge ? RW'(cur - trial) : RW'(cur);
				root_s[g+1] <= {root_s[g][N-2:0], ge};
				rad_s[g+1]  <= rad_s[g] << 2;
				tag_s[g+1]  <= tag_s[g];
			end
		end
	end

	assign out_valid = v_s[N];
	assign root      = root_s[N];
	assign nums_out  = tag_s[N];

endmodule

// File: hw/rtl/r2q_div.sv
module r2q_div (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               en,
	input  logic                                               in_valid,
	input  logic [r2q_pkg::ROOT_W-1:0]                         root,
	input  r2q_pkg::num_t                                      nums,
	output logic                                               out_valid,
	output logic [r2q_pkg::LANES-1:0][r2q_pkg::NUM_W-1:0]      quo,
	output r2q_pkg::tag_t                                      tag
);

	localparam int N  = r2q_pkg::NUM_W;
	localparam int DW = r2q_pkg::DIV_W;

	logic [r2q_pkg::LANES-1:0][N-1:0]  num_s [N+1];
	logic [r2q_pkg::LANES-1:0][DW-1:0] rem_s [N+1];
	logic [r2q_pkg::LANES-1:0][N-1:0]  quo_s [N+1];
	logic [DW-1:0]                     den_s [N+1];
	r2q_pkg::tag_t                     tag_s [N+1];
	logic                              v_s   [N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	// Dividend |n| * one + r for rounding to nearest, divisor 2r
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < r2q_pkg::LANES; l++) begin
				num_s[0][l] <= N'({nums.mag[l], {r2q_pkg::FRACTION_BITS{1'b0}}})
					+ N'(root);
			end
			rem_s[0]      <= '0;
			quo_s[0]      <= '0;
			den_s[0]      <= {root, 1'b0};
			tag_s[0].path <= nums.path;
			tag_s[0].neg  <= nums.neg;
			tag_s[0].root <= root;
		end
	end

	// One quotient bit per stage in each lane, restoring
	for (genvar g = 0; g < N; g++) begin : g_step
		logic [r2q_pkg::LANES-1:0][DW:0] cur;
		logic [r2q_pkg::LANES-1:0]       ge;

		always_comb begin
			for (int l = 0; l < r2q_pkg::LANES; l++) begin
				cur[l] = {rem_s[g][l], num_s[g][l][N-1]};
				ge[l]  = (cur[l] >= (DW+1)'(den_s[g]));
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < r2q_pkg::LANES; l++) begin
					rem_s[g+1][l] <= ge[l] ? DW'(cur[l] - (DW+1)'(den_s[g]))
						: DW'(cur[l]);
					quo_s[g+1][l] <= {quo_s[g][l][N-2:0], ge[l]};
					num_s[g+1][l] <= num_s[g][l] << 1;
				end
				den_s[g+1] <= den_s[g];
				tag_s[g+1] <= tag_s[g];
			end
		end
	end

	assign out_valid = v_s[N];
	assign quo       = quo_s[N];
	assign tag       = tag_s[N];

endmodule

// File: hw/rtl/r2q_checker.sv
module r2q_props (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  s_tvalid,
	input logic                                  s_tready,
	input logic                                  m_tvalid,
	input logic                                  m_tready,
	input logic [4*r2q_pkg::DATA_WIDTH-1:0]      m_tdata,
	input logic [1:0]                            m_tuser
);

	localparam int DW = r2q_pkg::DATA_WIDTH;

	// A stalled result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// No transfer in while the output is stalled
	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken during output stall");

	// An empty output never blocks the input
	a_free_in: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");

	// The component given by the root is never negative
	a_root_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |->
			(m_tuser != r2q_pkg::PATH_TRACE || !m_tdata[4*DW-1]) &&
			(m_tuser != r2q_pkg::PATH_ROW0  || !m_tdata[DW-1]) &&
			(m_tuser != r2q_pkg::PATH_ROW1  || !m_tdata[2*DW-1]) &&
			(m_tuser != r2q_pkg::PATH_ROW2  || !m_tdata[3*DW-1]))
		else $error("negative root component");

endmodule

bind rotation_matrix_to_quaternion_unit r2q_props u_r2q_props (.*);

// File: tb/sv/r2q_checker.sv
`timescale 1ns / 100ps
module r2q_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [143:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,
	input  logic [1:0]  m_tuser,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [1:0]       path;
		logic [3:0][15:0] q;
	} quat_t;

	quat_t quat_queue[$];

	// Integer square root, truncated
	function automatic longint unsigned int_sqrt(longint unsigned a);
		longint unsigned res, bit_val;
		res = 0;
		bit_val = 64'd1 << 62;
		while (bit_val > a) bit_val >>= 2;
		while (bit_val != 0) begin
			if (a >= res + bit_val) begin
				a -= res + bit_val;
				res = (res >> 1) + bit_val;
			end else begin
				res >>= 1;
			end
			bit_val >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned root_fx(longint arg);
		if (arg <= 0) return 0;
		return int_sqrt(longint'(arg) << r2q_pkg::FRACTION_BITS);
	endfunction

	// n/(2r), rounded to nearest with ties away from zero
	function automatic longint div_2r(longint n, longint unsigned r);
		longint unsigned mag, qv;
		if (r == 0) return 0;
		mag = (n < 0) ? -n : n;
		qv = ((mag << r2q_pkg::FRACTION_BITS) + r) / (2 * r);
		return (n < 0) ? -longint'(qv) : longint'(qv);
	endfunction

	function automatic logic [15:0] clip16(longint v);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	function automatic quat_t predict_quat(logic [143:0] d);
		longint m[3][3];
		longint qv[4];
		longint tr, one;
		longint unsigned r;
		int i, j, k;
		quat_t res;
		one = 1 << r2q_pkg::FRACTION_BITS;
		for (int a = 0; a < 3; a++)
			for (int b = 0; b < 3; b++)
				m[a][b] = longint'($signed(d[(a*3+b)*16 +: 16]));
		tr = m[0][0] + m[1][1] + m[2][2];
		if (tr > 0) begin
			r = root_fx(tr + one);
			qv[3] = (r + 1) >> 1;
			qv[0] = div_2r(m[2][1] - m[1][2], r);
			qv[1] = div_2r(m[0][2] - m[2][0], r);
			qv[2] = div_2r(m[1][0] - m[0][1], r);
			res.path = r2q_pkg::PATH_TRACE;
		end else begin
			i = 0;
			if (m[1][1] > m[0][0]) i = 1;
			if (m[2][2] > m[i][i]) i = 2;
			j = (i + 1) % 3;
			k = (j + 1) % 3;
			r = root_fx(m[i][i] - m[j][j] - m[k][k] + one);
			qv[i] = (r + 1) >> 1;
			qv[3] = div_2r(m[k][j] - m[j][k], r);
			qv[j] = div_2r(m[j][i] + m[i][j], r);
			qv[k] = div_2r(m[k][i] + m[i][k], r);
			res.path = 2'(i + 1);
		end
		for (int c = 0; c < 4; c++) res.q[c] = clip16(qv[c]);
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		$display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
	end
	assign pending = quat_queue.size();

	// Record expectations and compare each result transfer
	always @(posedge clk) begin
		quat_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) quat_queue.push_back(predict_quat(s_tdata));
			if (m_tvalid && m_tready) begin
				if (quat_queue.size() == 0) begin
					$display("%0t: result transfer with nothing expected", $realtime);
					fail_count++;
				end else begin
					want = quat_queue.pop_front();
					if (m_tdata[15:0] !== want.q[0]) report_mismatch("quat_x", m_tdata[15:0], want.q[0]);
					if (m_tdata[31:16] !== want.q[1]) report_mismatch("quat_y", m_tdata[31:16], want.q[1]);
					if (m_tdata[47:32] !== want.q[2]) report_mismatch("quat_z", m_tdata[47:32], want.q[2]);
					if (m_tdata[63:48] !== want.q[3]) report_mismatch("quat_w", m_tdata[63:48], want.q[3]);
					if (m_tuser !== want.path) report_mismatch("path_taken", 16'(m_tuser), 16'(want.path));
				end
			end
		end
	end
endmodule

// File: tb/sv/tb_rotation_matrix_to_quaternion_unit.sv
`timescale 1ns / 100ps
module tb_rotation_matrix_to_quaternion_unit;
	localparam int RANDOM_MATRICES = 1430;
	localparam int STALL_LIMIT     = 2000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [143:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;
	logic [1:0]   m_tuser;
	int           fail_count;
	int           pending;
	int           idle_cycles = 0;
	bit           sending_done = 0;

	always #1 clk = ~clk;

	rotation_matrix_to_quaternion_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	r2q_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.fail_count(fail_count), .pending(pending)
	);

	function automatic logic [15:0] pick_entry(int mode);
		case (mode)
			0: return 16'(int'($urandom_range(0, 32768)) - 16384);
			1: return 16'(int'($urandom_range(0, 4096)) - 2048);
			2: return 16'h7fff;
			3: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Build a matrix; wide mix of well-formed ranges, extremes and noise
	function automatic logic [143:0] random_matrix();
		logic [143:0] d;
		int mode;
		mode = $urandom_range(0, 9);
		for (int e = 0; e < 9; e++) begin
			if (mode < 4) d[e*16 +: 16] = pick_entry(0);
			else if (mode < 6) d[e*16 +: 16] = pick_entry(1);
			else if (mode < 8) d[e*16 +: 16] = pick_entry($urandom_range(0, 4));
			else d[e*16 +: 16] = pick_entry(4);
		end
		// Often force the diagonal negative or tied to steer the path
		if ($urandom_range(0, 3) == 0) begin
			d[0 +: 16] = -16'($urandom_range(0, 16384));
			d[64 +: 16] = ($urandom_range(0, 1)) ? d[0 +: 16] : -16'($urandom_range(0, 16384));
			d[128 +: 16] = ($urandom_range(0, 1)) ? d[64 +: 16] : -16'($urandom_range(0, 16384));
		end
		return d;
	endfunction

	function automatic logic [143:0] pack9(int e0, int e1, int e2, int e3, int e4,
		int e5, int e6, int e7, int e8);
		return {16'(e8), 16'(e7), 16'(e6), 16'(e5), 16'(e4), 16'(e3), 16'(e2),
			16'(e1), 16'(e0)};
	endfunction

	// Drop valid only across a gap, so back-to-back transfers keep it high
	task automatic send_matrix(logic [143:0] d);
		int gap;
		gap = $urandom_range(0, 6);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Random back-pressure on the result side, with calm stretches
	initial begin
		int wait_cycles;
		@(posedge arst_n);
		forever begin
			wait_cycles = ($urandom_range(0, 7) < 3) ? 0 : $urandom_range(0, 6);
			repeat (wait_cycles) begin
				m_tready <= 1'b0;
				@(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles <= 0;
		else if (!sending_done || pending != 0)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int flush;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed: identity, rotations, extremes and ties
		send_matrix(pack9(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
		send_matrix(pack9(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
		send_matrix(pack9(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
		send_matrix(pack9(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384));
		send_matrix(pack9(0, -16384, 0, 16384, 0, 0, 0, 0, 16384));
		send_matrix(pack9(0, 16384, 0, 16384, 0, 0, 0, 0, -16384));
		send_matrix(pack9(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_matrix(pack9(-5000, 100, 200, 300, -5000, 400, 500, 600, -5000));
		send_matrix(pack9(-5000, 100, 200, 300, -3000, 400, 500, 600, -3000));
		send_matrix(pack9(-16384, 1, 2, 3, -16384, 4, 5, 6, -16384));
		send_matrix(pack9(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768));
		send_matrix(pack9(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
		send_matrix(pack9(32767, -32768, -32768, 32767, 32767, -32768, 32767, 32767, 32767));
		send_matrix(pack9(-32768, 32767, 32767, 32767, -32768, 32767, 32767, 32767, 0));
		send_matrix(pack9(0, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0));
		send_matrix(pack9(-32768, -32768, -32768, -32768, 32767, -32768, -32768, -32768, 0));
		send_matrix(pack9(1, 0, 0, 0, 0, 0, 0, 0, 0));
		send_matrix(pack9(-1, 32767, 32767, -32768, 0, 0, -32768, 0, 0));
		send_matrix(pack9(-100, 5, 6, 7, 50, 8, 9, 10, 50));
		send_matrix(pack9(-32768, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
		for (int n = 0; n < RANDOM_MATRICES; n++) send_matrix(random_matrix());
		s_tvalid <= 1'b0;
		sending_done = 1;
		while (pending != 0) @(posedge clk);
		flush = 0;
		while (flush < 80) begin
			@(posedge clk);
			flush++;
		end
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
